/* design/ogu_pkg.sv */
// Package for the occupancy grid updater: grid geometry, operation codes,
// controller states and the cell word layout. No dependencies.
package ogu_pkg;

    localparam int GRID_SIDE  = 64;
    localparam int COORD_W    = $clog2(GRID_SIDE);
    localparam int CELLS      = GRID_SIDE * GRID_SIDE;
    localparam int IDX_W      = 2 * COORD_W;
    localparam int FIELD_W    = 6;
    localparam int LEVEL_W    = 8;
    localparam int STAMP_W    = 32;
    localparam int CELL_W     = LEVEL_W + STAMP_W;
    localparam int ERR_W      = COORD_W + 4;
    localparam int INTERVAL_W = 16;

    typedef enum logic [2:0] {
        OP_CLEAR = 3'd0,
        OP_AGE   = 3'd1,
        OP_SHIFT = 3'd2,
        OP_MARK  = 3'd3,
        OP_FREE  = 3'd4,
        OP_READ  = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_RD,
        ST_WR,
        ST_DONE
    } state_t;

    localparam logic REG_MAX_LEVEL     = 1'b0;
    localparam logic REG_FREE_INTERVAL = 1'b1;

    localparam logic [1:0] STEP_POS = 2'b01;
    localparam logic [1:0] STEP_NEG = 2'b11;

    function automatic logic in_grid(input logic [FIELD_W-1:0] v);
        return ({{(32-FIELD_W){1'b0}}, v} < 32'(GRID_SIDE));
    endfunction

endpackage

/* design/ogu_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ogu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/occupancy_grid_updater.sv */
// Occupancy grid updater top level: controller around one cell RAM.
// Depends on ogu_pkg and ogu_ram.
// Each cell visit passes through a RAM read state, then a modify and write-back state.
// Mark visits each cell on the line, free each cell of the span; clear and age
// visit every cell, and shift visits every cell once per moving axis.
// After reset a clearing pass zeroes every RAM cell; no beat is taken during
// it. Registers reset to max_level 5, free_interval 1000.
module occupancy_grid_updater (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic                           cfg_index,
    input  logic [ogu_pkg::INTERVAL_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [2:0]                     operation,
    input  logic [31:0]                    now,
    input  logic [5:0]                     ax,
    input  logic [5:0]                     ay,
    input  logic [5:0]                     bx,
    input  logic [5:0]                     by,
    input  logic signed [1:0]              step_x,
    input  logic signed [1:0]              step_y,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [7:0]                     level,
    output logic [31:0]                    stamp
);

    localparam int CW = ogu_pkg::COORD_W;
    localparam int IW = ogu_pkg::IDX_W;
    localparam int EW = ogu_pkg::ERR_W;
    localparam logic [IW-1:0] IDX_LAST = IW'(ogu_pkg::CELLS - 1);
    localparam logic [CW-1:0] COORD_LAST = CW'(ogu_pkg::GRID_SIDE - 1);
    localparam logic [IW-1:0] ROW_STEP = IW'(ogu_pkg::GRID_SIDE);
    localparam logic signed [1:0] STEP_POS_S = $signed(ogu_pkg::STEP_POS);
    localparam logic signed [1:0] STEP_NEG_S = $signed(ogu_pkg::STEP_NEG);

    ogu_pkg::state_t state_reg, state_next;
    logic [2:0]      op_reg, op_next;
    logic [31:0]     now_reg, now_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic [CW-1:0]   x_reg, x_next, y_reg, y_next, end_x_reg, end_x_next;
    logic signed [EW-1:0] err_reg, err_next;
    logic [CW:0]     cnt_reg, cnt_next, dmaj_reg, dmaj_next, dmin_reg, dmin_next;
    logic            incx_reg, incx_next, incy_reg, incy_next;
    logic            ymaj_reg, ymaj_next, desc_reg, desc_next, ypass_reg, ypass_next;
    logic [1:0]      sx_reg, sx_next, sy_reg, sy_next;
    logic [7:0]      max_level_reg;
    logic [15:0]     free_interval_reg;
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      level_reg, level_next, res_level_reg, res_level_next;
    logic [31:0]     stamp_reg, stamp_next, res_stamp_reg, res_stamp_next;

    logic            ram_we;
    logic [IW-1:0]   ram_waddr, ram_raddr;
    logic [ogu_pkg::CELL_W-1:0] ram_wdata, ram_rdata;

    logic [7:0]      cur_level, new_level;
    logic [31:0]     cur_stamp, new_stamp, age;
    logic [IW-1:0]   cell_idx, src_idx;
    logic            src_zero, walk_op, shift_last;
    logic signed [CW+1:0] dx, dy;
    logic [CW:0]     adx, ady;
    logic signed [EW-1:0] err_step;
    logic [CW-1:0]   clip_x;

    assign cur_level = ram_rdata[ogu_pkg::CELL_W-1 -: 8];
    assign cur_stamp = ram_rdata[31:0];
    assign cell_idx  = {y_reg, x_reg};
    assign walk_op   = (op_reg == ogu_pkg::OP_MARK) || (op_reg == ogu_pkg::OP_FREE)
                       || (op_reg == ogu_pkg::OP_READ);
    assign age       = now_reg - cur_stamp;
    assign err_step  = err_reg + EW'({dmin_reg, 1'b0});
    assign shift_last = desc_reg ? (idx_reg == '0) : (idx_reg == IDX_LAST);

    always_comb
    begin
        if (!ypass_reg)
        begin
            src_idx  = desc_reg ? idx_reg - IW'(1) : idx_reg + IW'(1);
            src_zero = desc_reg ? (idx_reg[CW-1:0] == '0) : (idx_reg[CW-1:0] == COORD_LAST);
        end
        else
        begin
            src_idx  = desc_reg ? idx_reg - ROW_STEP : idx_reg + ROW_STEP;
            src_zero = desc_reg ? (idx_reg[IW-1:CW] == '0) : (idx_reg[IW-1:CW] == COORD_LAST);
        end
    end

    always_comb
    begin
        dx  = $signed({2'b0, CW'(bx)}) - $signed({2'b0, CW'(ax)});
        dy  = $signed({2'b0, CW'(by)}) - $signed({2'b0, CW'(ay)});
        adx = dx[CW+1] ? (CW+1)'(-dx) : dx[CW:0];
        ady = dy[CW+1] ? (CW+1)'(-dy) : dy[CW:0];
        clip_x = ogu_pkg::in_grid(bx) ? CW'(bx) : COORD_LAST;
    end

    always_comb
    begin
        new_level = cur_level;
        new_stamp = cur_stamp;
        case (op_reg)
            ogu_pkg::OP_CLEAR:
            begin
                new_level = '0;
            end
            ogu_pkg::OP_AGE:
            begin
                if (cur_level != '0 && !age[31] && age > {16'b0, free_interval_reg})
                begin
                    new_level = cur_level - 8'd1;
                    new_stamp = now_reg;
                end
            end
            ogu_pkg::OP_SHIFT:
            begin
                if (src_zero)
                begin
                    new_level = '0;
                    new_stamp = '0;
                end
            end
            ogu_pkg::OP_MARK:
            begin
                if (cur_level < max_level_reg && cur_stamp != now_reg)
                begin
                    new_level = cur_level + 8'd1;
                end
                new_stamp = now_reg;
            end
            ogu_pkg::OP_FREE:
            begin
                if (cur_level != '0)
                begin
                    new_level = cur_level - 8'd1;
                end
                new_stamp = now_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        now_next = now_reg;
        idx_next = idx_reg;
        x_next = x_reg;
        y_next = y_reg;
        end_x_next = end_x_reg;
        err_next = err_reg;
        cnt_next = cnt_reg;
        dmaj_next = dmaj_reg;
        dmin_next = dmin_reg;
        incx_next = incx_reg;
        incy_next = incy_reg;
        ymaj_next = ymaj_reg;
        desc_next = desc_reg;
        ypass_next = ypass_reg;
        sx_next = sx_reg;
        sy_next = sy_reg;
        res_level_next = res_level_reg;
        res_stamp_next = res_stamp_reg;
        level_next = level_reg;
        stamp_next = stamp_reg;
        out_valid_next = out_valid_reg && out_stall;
        ram_we = 1'b0;
        ram_waddr = walk_op ? cell_idx : idx_reg;
        ram_wdata = {new_level, new_stamp};
        ram_raddr = walk_op ? cell_idx : ((op_reg == ogu_pkg::OP_SHIFT) ? src_idx : idx_reg);
        in_stall = (state_reg != ogu_pkg::ST_IDLE);

        case (state_reg)
            ogu_pkg::ST_INIT:
            begin
                ram_we = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = '0;
                idx_next = idx_reg + IW'(1);
                if (idx_reg == IDX_LAST)
                begin
                    state_next = ogu_pkg::ST_IDLE;
                end
            end
            ogu_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next = operation;
                    now_next = now;
                    res_level_next = '0;
                    res_stamp_next = '0;
                    idx_next = '0;
                    desc_next = 1'b0;
                    ypass_next = 1'b0;
                    sx_next = step_x;
                    sy_next = step_y;
                    x_next = CW'(ax);
                    y_next = CW'(ay);
                    state_next = ogu_pkg::ST_DONE;
                    case (operation)
                        ogu_pkg::OP_CLEAR, ogu_pkg::OP_AGE:
                        begin
                            state_next = ogu_pkg::ST_RD;
                        end
                        ogu_pkg::OP_SHIFT:
                        begin
                            if (step_x == STEP_POS_S || step_x == STEP_NEG_S)
                            begin
                                desc_next = (step_x == STEP_NEG_S);
                                idx_next = (step_x == STEP_NEG_S) ? IDX_LAST : '0;
                                state_next = ogu_pkg::ST_RD;
                            end
                            else if (step_y == STEP_POS_S || step_y == STEP_NEG_S)
                            begin
                                ypass_next = 1'b1;
                                desc_next = (step_y == STEP_NEG_S);
                                idx_next = (step_y == STEP_NEG_S) ? IDX_LAST : '0;
                                state_next = ogu_pkg::ST_RD;
                            end
                        end
                        ogu_pkg::OP_MARK:
                        begin
                            if (ogu_pkg::in_grid(ax) && ogu_pkg::in_grid(ay)
                                && ogu_pkg::in_grid(bx) && ogu_pkg::in_grid(by))
                            begin
                                incx_next = (dx > 0);
                                incy_next = (dy > 0);
                                ymaj_next = !(ady < adx);
                                dmaj_next = (ady < adx) ? adx : ady;
                                dmin_next = (ady < adx) ? ady : adx;
                                cnt_next = (ady < adx) ? adx : ady;
                                err_next = -$signed(EW'((ady < adx) ? adx : ady));
                                state_next = ogu_pkg::ST_RD;
                            end
                        end
                        ogu_pkg::OP_FREE:
                        begin
                            end_x_next = clip_x;
                            if (ogu_pkg::in_grid(ax) && ogu_pkg::in_grid(ay)
                                && !(CW'(ax) > clip_x))
                            begin
                                state_next = ogu_pkg::ST_RD;
                            end
                        end
                        ogu_pkg::OP_READ:
                        begin
                            if (ogu_pkg::in_grid(ax) && ogu_pkg::in_grid(ay))
                            begin
                                state_next = ogu_pkg::ST_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ogu_pkg::ST_RD:
            begin
                state_next = ogu_pkg::ST_WR;
            end
            ogu_pkg::ST_WR:
            begin
                state_next = ogu_pkg::ST_RD;
                ram_we = (op_reg != ogu_pkg::OP_READ);
                case (op_reg)
                    ogu_pkg::OP_SHIFT:
                    begin
                        if (shift_last)
                        begin
                            if (!ypass_reg && (sy_reg == STEP_POS_S || sy_reg == STEP_NEG_S))
                            begin
                                ypass_next = 1'b1;
                                desc_next = (sy_reg == STEP_NEG_S);
                                idx_next = (sy_reg == STEP_NEG_S) ? IDX_LAST : '0;
                            end
                            else
                            begin
                                state_next = ogu_pkg::ST_DONE;
                            end
                        end
                        else
                        begin
                            idx_next = desc_reg ? idx_reg - IW'(1) : idx_reg + IW'(1);
                        end
                    end
                    ogu_pkg::OP_MARK:
                    begin
                        if (cnt_reg == '0)
                        begin
                            state_next = ogu_pkg::ST_DONE;
                        end
                        else
                        begin
                            cnt_next = cnt_reg - (CW+1)'(1);
                            err_next = err_step;
                            if (ymaj_reg)
                            begin
                                y_next = incy_reg ? y_reg + CW'(1) : y_reg - CW'(1);
                                if (err_step > 0)
                                begin
                                    x_next = incx_reg ? x_reg + CW'(1) : x_reg - CW'(1);
                                end
                            end
                            else
                            begin
                                x_next = incx_reg ? x_reg + CW'(1) : x_reg - CW'(1);
                                if (err_step > 0)
                                begin
                                    y_next = incy_reg ? y_reg + CW'(1) : y_reg - CW'(1);
                                end
                            end
                            if (err_step > 0)
                            begin
                                err_next = err_step - EW'({dmaj_reg, 1'b0});
                            end
                        end
                    end
                    ogu_pkg::OP_FREE:
                    begin
                        if (x_reg == end_x_reg)
                        begin
                            state_next = ogu_pkg::ST_DONE;
                        end
                        else
                        begin
                            x_next = x_reg + CW'(1);
                        end
                    end
                    ogu_pkg::OP_READ:
                    begin
                        res_level_next = cur_level;
                        res_stamp_next = cur_stamp;
                        state_next = ogu_pkg::ST_DONE;
                    end
                    default:
                    begin
                        if (idx_reg == IDX_LAST)
                        begin
                            state_next = ogu_pkg::ST_DONE;
                        end
                        else
                        begin
                            idx_next = idx_reg + IW'(1);
                        end
                    end
                endcase
            end
            ogu_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    level_next = res_level_reg;
                    stamp_next = res_stamp_reg;
                    state_next = ogu_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ogu_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ogu_pkg::ST_INIT;
            idx_reg <= '0;
            out_valid_reg <= 1'b0;
            max_level_reg <= 8'd5;
            free_interval_reg <= 16'd1000;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write && cfg_index == ogu_pkg::REG_MAX_LEVEL)
            begin
                max_level_reg <= cfg_data[7:0];
            end
            if (cfg_write && cfg_index == ogu_pkg::REG_FREE_INTERVAL)
            begin
                free_interval_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        now_reg <= now_next;
        x_reg <= x_next;
        y_reg <= y_next;
        end_x_reg <= end_x_next;
        err_reg <= err_next;
        cnt_reg <= cnt_next;
        dmaj_reg <= dmaj_next;
        dmin_reg <= dmin_next;
        incx_reg <= incx_next;
        incy_reg <= incy_next;
        ymaj_reg <= ymaj_next;
        desc_reg <= desc_next;
        ypass_reg <= ypass_next;
        sx_reg <= sx_next;
        sy_reg <= sy_next;
        res_level_reg <= res_level_next;
        res_stamp_reg <= res_stamp_next;
        level_reg <= level_next;
        stamp_reg <= stamp_next;
    end

    ogu_ram #(
        .WIDTH(ogu_pkg::CELL_W),
        .DEPTH(ogu_pkg::CELLS)
    ) u_cells (
        .clk(clk),
        .we(ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign out_valid = out_valid_reg;
    assign level = level_reg;
    assign stamp = stamp_reg;

endmodule
